// ===== sv/ssd_pkg.sv =====
`default_nettype none

package ssd_pkg;

   localparam int DIGIT_COUNT = 4;
   localparam int SCAN_W      = 2;

   typedef enum logic [1:0] {
      KIND_TICK        = 2'd0,
      KIND_SET_HOURS   = 2'd1,
      KIND_SET_MINUTES = 2'd2,
      KIND_SOUND       = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      AUDIO_NONE    = 2'd0,
      AUDIO_POWERUP = 2'd1,
      AUDIO_PLAY    = 2'd2
   } audio_count_type;

   localparam logic [3:0]  BLANK_CODE  = 4'd10;
   localparam logic [3:0]  DIGIT_MAX   = 4'd9;
   localparam logic [7:0]  CMD_POWERUP = 8'hC5;
   localparam logic [7:0]  CMD_PLAY    = 8'h55;
   localparam logic [7:0]  GROUP_CHIME = 8'd0;
   localparam logic [7:0]  GROUP_ALARM = 8'd1;
   localparam logic [7:0]  HOURS_MAX   = 8'd23;
   localparam logic [7:0]  MINUTES_MAX = 8'd59;
   localparam logic [15:0] TPS_RESET   = 16'd5000;

   // digit select bits, one entry per scan position
   localparam logic [7:0] SEL_A [DIGIT_COUNT] = '{8'h04, 8'h02, 8'h00, 8'h00};
   localparam logic [7:0] SEL_B [DIGIT_COUNT] = '{8'h00, 8'h00, 8'h40, 8'h80};

   // segment bits per digit code, last entry is blank
   localparam logic [7:0] SEG_A [11] = '{8'h10, 8'h40, 8'h00, 8'h00, 8'h00, 8'h20,
                                         8'h80, 8'h08, 8'h00, 8'h00, 8'h00};
   localparam logic [7:0] SEG_B [11] = '{8'h00, 8'h00, 8'h02, 8'h08, 8'h20, 8'h00,
                                         8'h00, 8'h00, 8'h04, 8'h10, 8'h00};

   typedef struct packed {
      logic set;
      logic powerup;
      logic chime;
      logic alarm;
   } sound_req_type;

   typedef struct packed {
      audio_count_type count;
      logic [7:0]      byte_a;
      logic [7:0]      byte_b;
   } audio_type;

   // tens digit by reciprocal multiply, exact for values below 160
   function automatic logic [3:0] tens_of(input logic [7:0] v);
      logic [15:0] p;
      p = 16'(v) * 16'd205;
      return p[14:11];
   endfunction

   function automatic logic [3:0] ones_of(input logic [7:0] v, input logic [3:0] tens);
      logic [7:0] t;
      t = v - ({4'd0, tens} << 3) - ({4'd0, tens} << 1);
      return t[3:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/ssd_req_if.sv =====
`default_nettype none

interface ssd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] value;
   logic       day_mode;
   logic       req_powerup;
   logic       req_chime;
   logic       req_alarm;

   modport source (output valid, kind, value, day_mode, req_powerup, req_chime, req_alarm,
                   input ready);
   modport sink   (input valid, kind, value, day_mode, req_powerup, req_chime, req_alarm,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/ssd_rsp_if.sv =====
`default_nettype none

interface ssd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] first_byte;
   logic [7:0] second_byte;
   logic [1:0] audio_count;
   logic [7:0] audio_byte_a;
   logic [7:0] audio_byte_b;
   logic       second_pulse;

   modport source (output valid, first_byte, second_byte, audio_count, audio_byte_a,
                   audio_byte_b, second_pulse, input ready);
   modport sink   (input valid, first_byte, second_byte, audio_count, audio_byte_a,
                   audio_byte_b, second_pulse, output ready);
endinterface

`default_nettype wire

// ===== sv/ssd_sound_queue.sv =====
`default_nettype none

module ssd_sound_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ssd_pkg::sound_req_type sound_req,
   input  wire logic                   serve,
   output ssd_pkg::audio_type          audio
);
   import ssd_pkg::*;

   logic powerup_ff, chime_ff, alarm_ff;
   logic powerup_in, chime_in, alarm_in;

   always_comb begin
      audio.count  = AUDIO_NONE;
      audio.byte_a = 8'd0;
      audio.byte_b = 8'd0;
      priority if (powerup_ff) begin
         audio.count  = AUDIO_POWERUP;
         audio.byte_a = CMD_POWERUP;
      end else if (chime_ff) begin
         audio.count  = AUDIO_PLAY;
         audio.byte_a = CMD_PLAY;
         audio.byte_b = GROUP_CHIME;
      end else if (alarm_ff) begin
         audio.count  = AUDIO_PLAY;
         audio.byte_a = CMD_PLAY;
         audio.byte_b = GROUP_ALARM;
      end
   end

   always_comb begin
      powerup_in = powerup_ff;
      chime_in   = chime_ff;
      alarm_in   = alarm_ff;
      if (sound_req.set) begin
         powerup_in = powerup_ff | sound_req.powerup;
         chime_in   = chime_ff | sound_req.chime;
         alarm_in   = alarm_ff | sound_req.alarm;
      end else if (serve) begin
         // drop only the flag that was granted
         priority if (powerup_ff) begin
            powerup_in = 1'b0;
         end else if (chime_ff) begin
            chime_in = 1'b0;
         end else if (alarm_ff) begin
            alarm_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         powerup_ff <= 1'b1;
         chime_ff   <= 1'b0;
         alarm_ff   <= 1'b0;
      end else begin
         powerup_ff <= powerup_in;
         chime_ff   <= chime_in;
         alarm_ff   <= alarm_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/seven_segment_scan_with_sound_cmds.sv =====
`default_nettype none

// channel   dir  handshake    payload
// req_chan  in   valid/ready  kind, value, day_mode, req_powerup, req_chime, req_alarm
// rsp_chan  out  valid/ready  first_byte, second_byte, audio_count, audio_byte_a,
//                             audio_byte_b, second_pulse
// csr       in   write_en     write_data = ticks_per_second
//
// One item per cycle while no tick waits: an input register feeds a single combinational
// step into the result register, which captures each tick's result.
// Set and sound items update state and produce no result.
// Reset (synchronous) blanks all digits, clears scan and tick counters, and queues
// the power-up command; ticks_per_second returns to 5000.
// A tick waits in the input register only while the result register holds an
// untaken result; other items pass regardless of the output side.

module seven_segment_scan_with_sound_cmds (
   input  wire logic        clock,
   input  wire logic        reset,
   ssd_req_if.sink          req_chan,
   ssd_rsp_if.source        rsp_chan,
   input  wire logic        csr_write_en,
   input  wire logic [15:0] csr_write_data
);
   import ssd_pkg::*;

   // input register
   logic       in_valid_ff;
   logic [1:0] in_kind_ff;
   logic [7:0] in_value_ff;
   logic       in_day_ff;
   logic       in_powerup_ff, in_chime_ff, in_alarm_ff;

   // block state
   logic [15:0]       tps_ff;
   logic [3:0]        digit_ff [DIGIT_COUNT];
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic              half_ff;
   logic [15:0]       tick_count_ff, tick_count_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_first_ff, rsp_second_ff, rsp_aud_a_ff, rsp_aud_b_ff;
   logic [1:0] rsp_count_ff;
   logic       rsp_pulse_ff;

   logic          stage_fire, tick_fire, in_take;
   logic          hours_wr, minutes_wr;
   logic [3:0]    tens, ones, code;
   logic [7:0]    first_byte, second_byte;
   logic [16:0]   next_count;
   logic          pulse;
   sound_req_type sound_req;
   audio_type     audio;

   assign stage_fire = in_valid_ff &&
                       (in_kind_ff != KIND_TICK || !rsp_valid_ff || rsp_chan.ready);
   assign tick_fire  = stage_fire && in_kind_ff == KIND_TICK;
   assign req_chan.ready = !in_valid_ff || stage_fire;
   assign in_take    = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_take || (in_valid_ff && !stage_fire);
      end
      if (in_take) begin
         in_kind_ff    <= req_chan.kind;
         in_value_ff   <= req_chan.value;
         in_day_ff     <= req_chan.day_mode;
         in_powerup_ff <= req_chan.req_powerup;
         in_chime_ff   <= req_chan.req_chime;
         in_alarm_ff   <= req_chan.req_alarm;
      end
   end

   // set items
   assign tens       = tens_of(in_value_ff);
   assign ones       = ones_of(in_value_ff, tens);
   assign hours_wr   = stage_fire && in_kind_ff == KIND_SET_HOURS && in_value_ff <= HOURS_MAX;
   assign minutes_wr = stage_fire && in_kind_ff == KIND_SET_MINUTES &&
                       in_value_ff <= MINUTES_MAX;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            digit_ff[i] <= BLANK_CODE;
         end
      end else if (hours_wr) begin
         digit_ff[0] <= tens;
         digit_ff[1] <= ones;
      end else if (minutes_wr) begin
         digit_ff[2] <= tens;
         digit_ff[3] <= ones;
      end
   end

   // display bytes
   always_comb begin
      code = digit_ff[scan_ff];
      if (code > DIGIT_MAX) begin
         code = BLANK_CODE;
      end
      if (!in_day_ff && half_ff) begin
         first_byte  = 8'd0;
         second_byte = 8'd0;
      end else begin
         first_byte  = SEL_A[scan_ff] | SEG_A[code];
         second_byte = SEL_B[scan_ff] | SEG_B[code];
      end
   end

   // second counter
   assign next_count = {1'b0, tick_count_ff} + 17'd1;
   assign pulse      = next_count >= {1'b0, tps_ff};

   always_comb begin
      scan_in       = half_ff ? scan_ff : scan_ff + SCAN_W'(1);
      tick_count_in = pulse ? 16'd0 : next_count[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff        <= TPS_RESET;
         scan_ff       <= '0;
         half_ff       <= 1'b0;
         tick_count_ff <= 16'd0;
      end else begin
         if (csr_write_en) begin
            tps_ff <= csr_write_data;
         end
         if (tick_fire) begin
            scan_ff       <= scan_in;
            half_ff       <= !half_ff;
            tick_count_ff <= tick_count_in;
         end
      end
   end

   assign sound_req.set     = stage_fire && in_kind_ff == KIND_SOUND;
   assign sound_req.powerup = in_powerup_ff;
   assign sound_req.chime   = in_chime_ff;
   assign sound_req.alarm   = in_alarm_ff;

   ssd_sound_queue u_sound_queue (
      .clock     (clock),
      .reset     (reset),
      .sound_req (sound_req),
      .serve     (tick_fire),
      .audio     (audio)
   );

   // result register
   assign rsp_valid_in = tick_fire || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (tick_fire) begin
         rsp_first_ff  <= first_byte;
         rsp_second_ff <= second_byte;
         rsp_count_ff  <= audio.count;
         rsp_aud_a_ff  <= audio.byte_a;
         rsp_aud_b_ff  <= audio.byte_b;
         rsp_pulse_ff  <= pulse;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.first_byte   = rsp_first_ff;
   assign rsp_chan.second_byte  = rsp_second_ff;
   assign rsp_chan.audio_count  = rsp_count_ff;
   assign rsp_chan.audio_byte_a = rsp_aud_a_ff;
   assign rsp_chan.audio_byte_b = rsp_aud_b_ff;
   assign rsp_chan.second_pulse = rsp_pulse_ff;

`ifndef NO_ASSERTIONS
   a_pulse_restarts_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_pulse_ff |-> tick_count_ff == 16'd0)
      else $error("second pulse shown but tick counter not restarted");

   a_no_audio_no_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_count_ff == AUDIO_NONE |-> rsp_aud_a_ff == 8'd0 &&
      rsp_aud_b_ff == 8'd0)
      else $error("audio bytes set without a command");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !stage_fire |=> in_valid_ff && $stable(in_kind_ff) &&
      $stable(in_value_ff))
      else $error("stalled input transaction lost");

   a_non_tick_no_result: assert property (@(posedge clock) disable iff (reset)
      stage_fire && in_kind_ff != KIND_TICK |=>
      rsp_valid_ff == $past(rsp_valid_ff && !rsp_chan.ready))
      else $error("result produced by a non-tick transaction");

   a_tick_blocked_on_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !tick_fire)
      else $error("tick overwrote an untaken result");
`endif

endmodule

`default_nettype wire
